// ===== rtl/otb_pkg.sv =====
package otb_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] RESET_MAX_DELAY = 32'h7FFF_FFFF;
  localparam logic [15:0] RESET_PAD       = 16'd16;
  localparam logic [31:0] RESET_DUE       = 32'd0 - {16'd0, RESET_PAD};

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_SET    = 2'd1,
    FN_CANCEL = 2'd2,
    FN_QUERY  = 2'd3
  } func_e;

  typedef enum logic {
    REG_MAX_DELAY  = 1'b0,
    REG_CANCEL_PAD = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_FIRE   = 1'b0,
    KIND_ANSWER = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    A_NOW   = 2'd0,
    A_DUE   = 2'd1,
    A_DELAY = 2'd2
  } a_sel_e;

  typedef enum logic [2:0] {
    B_ONE = 3'd0,
    B_NOW = 3'd1,
    B_MAX = 3'd2,
    B_PAD = 3'd3,
    B_SAT = 3'd4
  } b_sel_e;

  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    logic              sub;
    logic              now_we;
    logic              due_we;
    logic              due_from_now;
    logic              sat_we;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] res;
    logic        zero;
    logic        above_max;
  } dp_sts_t;

endpackage

// ===== rtl/otb_req_if.sv =====
interface otb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  slot;
  logic [31:0] delay;

  modport source (output valid, func, slot, delay, input ready);
  modport sink   (input valid, func, slot, delay, output ready);
endinterface

// ===== rtl/otb_rsp_if.sv =====
interface otb_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  event_slot;
  logic [31:0] remaining;
  logic        last;

  modport source (output valid, kind, event_slot, remaining, last, input ready);
  modport sink   (input valid, kind, event_slot, remaining, last, output ready);
endinterface

// ===== rtl/otb_cfg.sv =====
module otb_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] max_delay_o,
  output logic [15:0] cancel_pad_o
);

  logic [31:0]       max_delay_q;
  logic [15:0]       cancel_pad_q;
  otb_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = otb_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q  <= otb_pkg::RESET_MAX_DELAY;
      cancel_pad_q <= otb_pkg::RESET_PAD;
    end else if (wr_en) begin
      unique case (reg_idx)
        otb_pkg::REG_MAX_DELAY:  max_delay_q  <= pwdata;
        otb_pkg::REG_CANCEL_PAD: cancel_pad_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      otb_pkg::REG_MAX_DELAY:  prdata = max_delay_q;
      otb_pkg::REG_CANCEL_PAD: prdata = {16'd0, cancel_pad_q};
      default:                 prdata = '0;
    endcase
  end

  assign max_delay_o  = max_delay_q;
  assign cancel_pad_o = cancel_pad_q;

endmodule

// ===== rtl/otb_dp.sv =====
module otb_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  otb_pkg::dp_cmd_t cmd_i,
  input  logic [31:0]      delay_i,
  input  logic [31:0]      max_delay_i,
  input  logic [15:0]      cancel_pad_i,
  output otb_pkg::dp_sts_t sts_o
);

  logic [31:0] now_q;
  logic [31:0] due_q [otb_pkg::SLOTS];
  logic [31:0] sat_q;
  logic [31:0] a_val;
  logic [31:0] b_val;
  logic [32:0] sum;

  // shared adder / subtractor
  always_comb begin
    case (cmd_i.a_sel)
      otb_pkg::A_NOW:   a_val = now_q;
      otb_pkg::A_DUE:   a_val = due_q[cmd_i.idx];
      otb_pkg::A_DELAY: a_val = delay_i;
      default:          a_val = now_q;
    endcase
    case (cmd_i.b_sel)
      otb_pkg::B_ONE: b_val = 32'd1;
      otb_pkg::B_NOW: b_val = now_q;
      otb_pkg::B_MAX: b_val = max_delay_i;
      otb_pkg::B_PAD: b_val = {16'd0, cancel_pad_i};
      otb_pkg::B_SAT: b_val = sat_q;
      default:        b_val = 32'd1;
    endcase
    sum = {1'b0, a_val} + {1'b0, b_val ^ {32{cmd_i.sub}}} + {32'd0, cmd_i.sub};
  end

  assign sts_o.res       = sum[31:0];
  assign sts_o.zero      = (sum[31:0] == 32'd0);
  assign sts_o.above_max = (sum[31:0] > max_delay_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      for (int i = 0; i < otb_pkg::SLOTS; i++) begin
        due_q[i] <= otb_pkg::RESET_DUE;
      end
    end else begin
      if (cmd_i.now_we) begin
        now_q <= sum[31:0];
      end
      if (cmd_i.due_we) begin
        due_q[cmd_i.idx] <= cmd_i.due_from_now ? now_q : sum[31:0];
      end
    end
  end

  // carry out set means delay >= max_delay
  always_ff @(posedge clk_i) begin
    if (cmd_i.sat_we) begin
      sat_q <= sum[32] ? max_delay_i : delay_i;
    end
  end

endmodule

// ===== rtl/otb_seq.sv =====
module otb_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  otb_req_if.sink          req_i,
  otb_rsp_if.source        rsp_o,
  output otb_pkg::dp_cmd_t cmd_o,
  input  otb_pkg::dp_sts_t sts_i,
  output logic [31:0]      delay_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_SCAN,
    S_PULL,
    S_EMIT,
    S_SAT,
    S_SET,
    S_PARK,
    S_FIRE,
    S_QUERY
  } state_e;

  localparam logic [otb_pkg::SLOT_W-1:0] LAST_IDX = otb_pkg::SLOT_W'(otb_pkg::SLOTS - 1);

  state_e                       state_q;
  otb_pkg::func_e               func_q;
  logic [2:0]                   slot_q;
  logic [31:0]                  delay_q;
  logic [otb_pkg::SLOT_W-1:0]   idx_q;
  logic [otb_pkg::SLOT_W-1:0]   ptr_q;
  logic [otb_pkg::SLOTS-1:0]    mask_q;
  logic                         out_valid_q;
  logic                         out_kind_q;
  logic [2:0]                   out_slot_q;
  logic [31:0]                  out_rem_q;
  logic                         out_last_q;

  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  logic                         in_range;
  logic [otb_pkg::SLOT_W-1:0]   slot_idx;
  logic [otb_pkg::SLOTS-1:0]    low_c;
  logic [otb_pkg::SLOTS-1:0]    rest_c;
  logic [otb_pkg::SLOT_W-1:0]   first_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = out_free && (((state_q == S_EMIT) && (mask_q != '0)) ||
                                    (state_q == S_FIRE) || (state_q == S_QUERY));
  assign in_range    = ({3'd0, req_i.slot} < 6'(otb_pkg::SLOTS));
  assign slot_idx    = otb_pkg::SLOT_W'(slot_q);
  assign delay_o     = delay_q;

  // lowest pending fire
  always_comb begin
    low_c     = mask_q & (~mask_q + otb_pkg::SLOTS'(1));
    rest_c    = mask_q & ~low_c;
    first_idx = '0;
    for (int i = 0; i < otb_pkg::SLOTS; i++) begin
      if (low_c[i]) begin
        first_idx = otb_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    cmd_o              = '0;
    cmd_o.a_sel        = otb_pkg::A_NOW;
    cmd_o.b_sel        = otb_pkg::B_ONE;
    unique case (state_q)
      S_INC: begin
        cmd_o.now_we = 1'b1;
      end
      S_SCAN: begin
        cmd_o.idx   = idx_q;
        cmd_o.a_sel = otb_pkg::A_DUE;
        cmd_o.b_sel = otb_pkg::B_NOW;
        cmd_o.sub   = 1'b1;
      end
      S_PULL: begin
        cmd_o.idx          = ptr_q;
        cmd_o.a_sel        = otb_pkg::A_DUE;
        cmd_o.b_sel        = otb_pkg::B_NOW;
        cmd_o.sub          = 1'b1;
        cmd_o.due_we       = sts_i.above_max;
        cmd_o.due_from_now = 1'b1;
      end
      S_SAT: begin
        cmd_o.a_sel  = otb_pkg::A_DELAY;
        cmd_o.b_sel  = otb_pkg::B_MAX;
        cmd_o.sub    = 1'b1;
        cmd_o.sat_we = 1'b1;
      end
      S_SET: begin
        cmd_o.idx    = slot_idx;
        cmd_o.b_sel  = otb_pkg::B_SAT;
        cmd_o.due_we = 1'b1;
      end
      S_PARK: begin
        cmd_o.idx    = slot_idx;
        cmd_o.b_sel  = otb_pkg::B_PAD;
        cmd_o.sub    = 1'b1;
        cmd_o.due_we = 1'b1;
      end
      S_QUERY: begin
        cmd_o.idx   = slot_idx;
        cmd_o.a_sel = otb_pkg::A_DUE;
        cmd_o.b_sel = otb_pkg::B_NOW;
        cmd_o.sub   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q  <= otb_pkg::func_e'(req_i.func);
            slot_q  <= req_i.slot;
            delay_q <= req_i.delay;
            case (otb_pkg::func_e'(req_i.func))
              otb_pkg::FN_TICK:   state_q <= S_INC;
              otb_pkg::FN_SET:    state_q <= !in_range ? S_IDLE :
                                             (req_i.delay == 32'd0) ? S_PARK : S_SAT;
              otb_pkg::FN_CANCEL: state_q <= in_range ? S_PARK : S_IDLE;
              otb_pkg::FN_QUERY:  state_q <= in_range ? S_QUERY : S_IDLE;
              default:            state_q <= S_IDLE;
            endcase
          end
        end
        S_INC: begin
          idx_q   <= '0;
          mask_q  <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          mask_q[idx_q] <= sts_i.zero;
          if (idx_q == LAST_IDX) begin
            state_q <= S_PULL;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_PULL: begin
          ptr_q   <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (mask_q == '0) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= otb_pkg::KIND_FIRE;
            out_slot_q  <= 3'(first_idx);
            out_rem_q   <= '0;
            out_last_q  <= (rest_c == '0);
            mask_q      <= rest_c;
            if (rest_c == '0) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_SAT: begin
          state_q <= S_SET;
        end
        S_SET: begin
          state_q <= S_IDLE;
        end
        S_PARK: begin
          state_q <= (func_q == otb_pkg::FN_SET) ? S_FIRE : S_IDLE;
        end
        S_FIRE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= otb_pkg::KIND_FIRE;
            out_slot_q  <= slot_q;
            out_rem_q   <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_QUERY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= otb_pkg::KIND_ANSWER;
            out_slot_q  <= slot_q;
            out_rem_q   <= sts_i.res;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.kind       = out_kind_q;
  assign rsp_o.event_slot = out_slot_q;
  assign rsp_o.remaining  = out_rem_q;
  assign rsp_o.last       = out_last_q;

  a_tick_starts_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.func == otb_pkg::FN_TICK) |=> state_q == S_INC)
    else $error("tick request did not start the counter update");

  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && out_free && (mask_q != '0) && (rest_c == '0)
    |=> (mask_q == '0) && (state_q == S_IDLE) && rsp_o.valid && rsp_o.last)
    else $error("final fire event left pending fires or state");

  a_query_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QUERY) && out_free
    |=> rsp_o.valid && (rsp_o.kind == otb_pkg::KIND_ANSWER) && rsp_o.last)
    else $error("query answer not presented");

endmodule

// ===== rtl/one_shot_timer_bank_unit.sv =====
// bank of one-shot timer slots sharing a 32-bit wrapping tick counter
// req_i: valid/ready request channel carrying func, slot and delay
//   tick advances the counter, set arms a slot, cancel parks it, query reads it
// rsp_o: valid/ready result channel carrying kind, event_slot, remaining, last
//   a tick gives one fire event per matching slot in slot order, last on the final
// apb port: max_delay at 0x0, cancel_padding at 0x4, always ready
// one shared 32-bit adder/subtractor does all arithmetic under a sequencer
// tick: a counter update step, a compare step for each of the 8 slots, a pull-in step,
//   then the emit step, giving the fire events one at a time
// set: saturate step, then set step; set with zero delay: park, then fire
//   cancel uses the park step, query the query step
// one request is worked on at a time; the result register lets the next
//   request in while the last result waits for the receiver
// a stalled receiver holds the sequencer in its emit, fire or query step until taken
// reset: counter zero, all slots due at zero minus the padding reset,
//   pull-in pointer zero, registers at their reset values, output empty
module one_shot_timer_bank_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  otb_req_if.sink     req_i,
  otb_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]      max_delay;
  logic [15:0]      cancel_pad;
  logic [31:0]      delay;
  otb_pkg::dp_cmd_t cmd;
  otb_pkg::dp_sts_t sts;

  otb_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_delay_o  (max_delay),
    .cancel_pad_o (cancel_pad)
  );

  otb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .delay_i      (delay),
    .max_delay_i  (max_delay),
    .cancel_pad_i (cancel_pad),
    .sts_o        (sts)
  );

  otb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .cmd_o   (cmd),
    .sts_i   (sts),
    .delay_o (delay)
  );

endmodule
